// ===== sv/idv_pkg.sv =====
// Package: types, constants and per-character functions of the ID number validator.
`default_nettype none

package idv_pkg;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_WS_LO   = 8'd9;
    localparam logic [7:0] CHAR_WS_HI   = 8'd13;
    localparam logic [3:0] TOTAL_DIGITS = 4'd13;
    localparam logic [3:0] SPACE_POS_A  = 4'd4;
    localparam logic [3:0] SPACE_POS_B  = 4'd9;
    localparam logic [3:0] CHECK_POS    = 4'd8;
    localparam logic [3:0] REGION_END   = 4'd11;
    localparam logic [6:0] NUM_REGIONS  = 7'd22;
    localparam int         CHECK_MOD    = 11;

    typedef enum logic [2:0] {
        RSN_VALID     = 3'd0,
        RSN_EMPTY     = 3'd1,
        RSN_FORMAT    = 3'd2,
        RSN_ZERO_CODE = 3'd3,
        RSN_REGION_HI = 3'd4,
        RSN_SUB_HI    = 3'd5,
        RSN_CHECK     = 3'd6
    } t_reason;

    typedef struct packed {
        logic [3:0] digit_count;
        logic       space_taken;
        logic       format_bad;
        logic       chars_seen;
        logic [3:0] wsum;
        logic [3:0] check_digit;
        logic [6:0] region;
        logic [6:0] subregion;
    } t_state;

    typedef struct packed {
        logic       advance;
        logic [7:0] ch;
        logic       no_char;
        logic       last;
    } t_step;

    localparam t_state STATE_RESET = '0;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_WS_LO && c <= CHAR_WS_HI);
    endfunction

    // value below 99 reduced mod 11 by parallel threshold compares
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [6:0] r;
        r = x;
        for (int k = 1; k <= 8; k++) begin
            if (x >= 7'(CHECK_MOD * k)) begin
                r = x - 7'(CHECK_MOD * k);
            end
        end
        return r[3:0];
    endfunction

    function automatic logic [6:0] sub_limit(input logic [4:0] idx);
        logic [6:0] lim;
        case (idx)
            5'd0:    lim = 7'd17;
            5'd1:    lim = 7'd8;
            5'd2:    lim = 7'd16;
            5'd3:    lim = 7'd16;
            5'd4:    lim = 7'd13;
            5'd5:    lim = 7'd14;
            5'd6:    lim = 7'd19;
            5'd7:    lim = 7'd8;
            5'd8:    lim = 7'd24;
            5'd9:    lim = 7'd21;
            5'd10:   lim = 7'd9;
            5'd11:   lim = 7'd30;
            5'd12:   lim = 7'd32;
            5'd13:   lim = 7'd21;
            5'd14:   lim = 7'd8;
            5'd15:   lim = 7'd17;
            5'd16:   lim = 7'd14;
            5'd17:   lim = 7'd5;
            5'd18:   lim = 7'd11;
            5'd19:   lim = 7'd11;
            5'd20:   lim = 7'd7;
            5'd21:   lim = 7'd17;
            default: lim = 7'd0;
        endcase
        return lim;
    endfunction

    function automatic t_state take_byte(input t_state s, input logic [7:0] c);
        t_state     n;
        logic [3:0] d;
        logic [6:0] prod;
        n = s;
        n.chars_seen = 1'b1;
        d = 4'(c - CHAR_ZERO);
        prod = 7'({3'b000, d} * (7'(s.digit_count) + 7'd2));
        if (!s.format_bad) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (s.digit_count >= TOTAL_DIGITS) begin
                    n.format_bad = 1'b1;
                end else begin
                    if (s.digit_count < CHECK_POS) begin
                        n.wsum = mod11(7'(s.wsum) + prod);
                    end else if (s.digit_count == CHECK_POS) begin
                        n.check_digit = d;
                    end else if (s.digit_count < REGION_END) begin
                        n.region = 7'(s.region * 7'd10 + 7'(d));
                    end else begin
                        n.subregion = 7'(s.subregion * 7'd10 + 7'(d));
                    end
                    n.digit_count = s.digit_count + 4'd1;
                    n.space_taken = 1'b0;
                end
            end else if (is_ws(c)) begin
                if ((s.digit_count == SPACE_POS_A || s.digit_count == SPACE_POS_B)
                        && !s.space_taken) begin
                    n.space_taken = 1'b1;
                end else begin
                    n.format_bad = 1'b1;
                end
            end else begin
                n.format_bad = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic t_reason verdict(input t_state s);
        t_reason r;
        if (!s.chars_seen) begin
            r = RSN_EMPTY;
        end else if (s.format_bad || s.digit_count != TOTAL_DIGITS) begin
            r = RSN_FORMAT;
        end else if (s.region == 7'd0 || s.subregion == 7'd0) begin
            r = RSN_ZERO_CODE;
        end else if (s.region > NUM_REGIONS) begin
            r = RSN_REGION_HI;
        end else if (s.subregion > sub_limit(5'(s.region - 7'd1))) begin
            r = RSN_SUB_HI;
        end else if (s.wsum != s.check_digit) begin
            r = RSN_CHECK;
        end else begin
            r = RSN_VALID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/idv_if.sv =====
// Stream interfaces: character beats in, verdict beats out.
`default_nettype none

interface idv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       no_char;
    logic       last;

    modport source (output valid, output ch, output no_char, output last, input ready);
    modport sink   (input valid, input ch, input no_char, input last, output ready);
endinterface

interface idv_out_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [2:0] reason;

    modport source (output valid, output valid_res, output reason, input ready);
    modport sink   (input valid, input valid_res, input reason, output ready);
endinterface

`default_nettype wire

// ===== sv/id_number_check_digit_validator_top.sv =====
// Top level: input register, per-string accumulator and verdict register.
`default_nettype none

// Checks an identity number streamed one character per beat (4 digits, optional
// whitespace, 5 digits, optional whitespace, 4 digits) and returns one verdict
// beat for each beat marked last: a mod-11 weighted check digit, region 1..22
// and a per-region subregion limit. One beat is taken every cycle but in a
// stall; an accepted beat waits in the input register, and for a last beat the
// verdict is formed combinationally and loaded into the output register.
// Input beats stall only when a last beat waits behind an unread verdict.
module id_number_check_digit_validator_top
    import idv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    idv_in_if.sink     i_in,
    idv_out_if.source  o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_no_char;
    logic       r_in_last;

    logic       r_out_valid;
    logic       r_valid_res;
    t_reason    r_reason;

    logic       advance;
    t_step      step;
    t_reason    reason;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign step = '{advance: advance, ch: r_in_ch, no_char: r_in_no_char, last: r_in_last};

    idv_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_reason (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ch      <= i_in.ch;
            r_in_no_char <= i_in.no_char;
            r_in_last    <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_reason    <= reason;
            r_valid_res <= (reason == RSN_VALID) || (reason == RSN_EMPTY);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.valid_res = r_valid_res;
    assign o_res.reason    = r_reason;

`ifndef NO_ASSERTIONS
    a_last_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_out_valid)
        else $error("last beat did not produce a verdict");

    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_valid_res ==
            ((r_reason == RSN_VALID) || (r_reason == RSN_EMPTY))))
        else $error("valid_res disagrees with reason");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !o_res.ready |=> r_in_valid)
        else $error("last beat dropped while verdict stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/idv_accum.sv =====
// Per-string state register, character update and verdict logic.
`default_nettype none

module idv_accum
    import idv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_reason      o_reason
);

    t_state r_state;
    t_state n_state;
    t_state upd;

    always_comb begin
        upd = i_step.no_char ? r_state : take_byte(r_state, i_step.ch);
        o_reason = verdict(upd);
        n_state = i_step.last ? STATE_RESET : upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_step.advance) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_id_number_check_digit_validator_top.sv =====
// Testbench for the ID number check-digit validator: random character streams, scoreboard.
`default_nettype none

module tb_id_number_check_digit_validator_top;
    import idv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BEAT_TARGET = 1600;

    typedef struct {
        logic    valid_res;
        t_reason reason;
    } t_verdict;

    typedef enum int {
        FLAW_REPLACE,
        FLAW_EXTRA_WS,
        FLAW_DROP,
        FLAW_EXTRA_DIGIT,
        FLAW_LEAD_WS,
        FLAW_TRAIL_WS
    } t_flaw;

    class id_verdict_board;
        int unsigned digit_count;
        bit          space_taken;
        bit          format_bad;
        bit          chars_seen;
        int unsigned wsum;
        int unsigned check_digit;
        int unsigned region_code;
        int unsigned subregion_code;
        int          sub_cap[22];
        t_verdict    verdict_q[$];
        int          fail_count;
        int          beats_taken;
        int          verdicts_seen;
        int          reason_hits[8];

        function new();
            sub_cap = '{17, 8, 16, 16, 13, 14, 19, 8, 24, 21, 9,
                        30, 32, 21, 8, 17, 14, 5, 11, 11, 7, 17};
            fail_count = 0;
            beats_taken = 0;
            verdicts_seen = 0;
            foreach (reason_hits[k]) reason_hits[k] = 0;
            clear();
        endfunction

        function void clear();
            digit_count = 0;
            space_taken = 0;
            format_bad = 0;
            chars_seen = 0;
            wsum = 0;
            check_digit = 0;
            region_code = 0;
            subregion_code = 0;
        endfunction

        function void absorb_char(logic [7:0] c);
            int unsigned d;
            chars_seen = 1;
            if (format_bad) return;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - CHAR_ZERO;
                if (digit_count >= 13) begin
                    format_bad = 1;
                    return;
                end
                if (digit_count < 8) wsum = (wsum + d * (digit_count + 2)) % 11;
                else if (digit_count == 8) check_digit = d;
                else if (digit_count < 11) region_code = region_code * 10 + d;
                else subregion_code = subregion_code * 10 + d;
                digit_count++;
                space_taken = 0;
            end else if (c == CHAR_SPACE || (c >= CHAR_WS_LO && c <= CHAR_WS_HI)) begin
                if ((digit_count == 4 || digit_count == 9) && !space_taken) space_taken = 1;
                else format_bad = 1;
            end else begin
                format_bad = 1;
            end
        endfunction

        function t_reason judge();
            if (!chars_seen) return RSN_EMPTY;
            if (format_bad || digit_count != 13) return RSN_FORMAT;
            if (region_code == 0 || subregion_code == 0) return RSN_ZERO_CODE;
            if (region_code > 22) return RSN_REGION_HI;
            if (subregion_code > sub_cap[region_code - 1]) return RSN_SUB_HI;
            if (wsum != check_digit) return RSN_CHECK;
            return RSN_VALID;
        endfunction

        function void note_beat(logic [7:0] ch, logic no_char, logic last);
            t_verdict v;
            if (!(no_char && !last)) beats_taken++;
            if (!no_char) absorb_char(ch);
            if (last) begin
                v.reason = judge();
                v.valid_res = (v.reason == RSN_VALID || v.reason == RSN_EMPTY);
                verdict_q.push_back(v);
                clear();
            end
        endfunction

        function void check_verdict(logic valid_res, logic [2:0] reason);
            t_verdict v;
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: verdict valid_res=%0b reason=%0d with none expected",
                             $realtime, valid_res, reason);
                return;
            end
            v = verdict_q.pop_front();
            verdicts_seen++;
            reason_hits[v.reason]++;
            if (valid_res !== v.valid_res || reason !== v.reason) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"%0t: verdict mismatch: expected valid_res=%0b reason=%0d,",
                              " got valid_res=%0b reason=%0d"},
                             $realtime, v.valid_res, v.reason, valid_res, reason);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    idv_in_if  char_if();
    idv_out_if verdict_if();

    id_number_check_digit_validator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_res   (verdict_if)
    );

    id_verdict_board board;
    logic [7:0]      text_q[$];
    bit              calm;
    int              hold_cycles;
    int              string_count;

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random back-pressure, long hold-off on request
    initial begin
        verdict_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                verdict_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                verdict_if.ready <= calm || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && verdict_if.valid && verdict_if.ready)
                board.check_verdict(verdict_if.valid_res, verdict_if.reason);
        end
    end

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CHAR_SPACE : 8'(r);
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic no_char, input logic last);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 10) begin
            char_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_if.valid   <= 1'b1;
        char_if.ch      <= ch;
        char_if.no_char <= no_char;
        char_if.last    <= last;
        do @(posedge i_clk); while (!char_if.ready);
        board.note_beat(ch, no_char, last);
    endtask

    // end mark rides on the final byte unless mark_alone or the text is empty
    task automatic send_text(input bit mark_alone);
        for (int i = 0; i < text_q.size(); i++) begin
            if ($urandom_range(0, 29) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_beat(text_q[i], 1'b0, (i == text_q.size() - 1) && !mark_alone);
        end
        if (mark_alone || text_q.size() == 0) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic compose_number();
        int kind;
        int region;
        int sub;
        int wsum;
        int dig[13];
        kind = $urandom_range(0, 99);
        wsum = 0;
        for (int i = 0; i < 8; i++) begin
            dig[i] = $urandom_range(0, 9);
            wsum = (wsum + dig[i] * (i + 2)) % 11;
        end
        if (kind < 50) begin
            region = $urandom_range(1, 22);
            sub = $urandom_range(1, board.sub_cap[region - 1]);
        end else if (kind < 58) begin
            region = $urandom_range(0, 22);
            sub = (region == 0) ? $urandom_range(0, 99) : 0;
        end else if (kind < 68) begin
            region = $urandom_range(23, 99);
            sub = $urandom_range(1, 99);
        end else if (kind < 80) begin
            region = $urandom_range(1, 22);
            sub = $urandom_range(board.sub_cap[region - 1] + 1, 99);
        end else begin
            region = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
        end
        dig[8] = (wsum < 10 && $urandom_range(0, 4) != 0) ? wsum : $urandom_range(0, 9);
        dig[9] = region / 10;
        dig[10] = region % 10;
        dig[11] = sub / 10;
        dig[12] = sub % 10;
        text_q.delete();
        for (int i = 0; i < 13; i++) begin
            text_q.push_back(CHAR_ZERO + 8'(dig[i]));
            if ((i == 3 || i == 8) && $urandom_range(0, 1)) text_q.push_back(ws_byte());
        end
    endtask

    task automatic corrupt_text();
        int    pos;
        t_flaw flaw;
        pos = $urandom_range(0, text_q.size() - 1);
        flaw = t_flaw'($urandom_range(FLAW_REPLACE, FLAW_TRAIL_WS));
        case (flaw)
            FLAW_REPLACE:     text_q[pos] = 8'($urandom_range(0, 255));
            FLAW_EXTRA_WS:    text_q.insert(pos, ws_byte());
            FLAW_DROP:        text_q.delete(pos);
            FLAW_EXTRA_DIGIT: text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            FLAW_LEAD_WS:     text_q.push_front(ws_byte());
            default:          text_q.push_back(ws_byte());
        endcase
    endtask

    task automatic compose_noise(input int max_len);
        int len;
        int pick;
        len = $urandom_range(1, max_len);
        text_q.delete();
        repeat (len) begin
            pick = $urandom_range(0, 3);
            if (pick < 2) text_q.push_back(8'($urandom_range(0, 255)));
            else if (pick == 2) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            else text_q.push_back(ws_byte());
        end
    endtask

    task automatic random_string();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            compose_number();
            if ($urandom_range(0, 4) == 0) corrupt_text();
        end else if (pick < 90) begin
            compose_noise(8);
        end else begin
            text_q.delete();
        end
        send_text(1'($urandom_range(0, 1)));
    endtask

    initial begin
        board = new();
        calm = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        char_if.valid = 1'b0;
        char_if.ch = '0;
        char_if.no_char = 1'b0;
        char_if.last = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, extreme bytes, leading whitespace, a clean valid number
        text_q.delete();
        send_text(1'b1);
        text_q = '{8'h00};
        send_text(1'b0);
        text_q = '{8'hFF};
        send_text(1'b0);
        load_text("\t");
        send_text(1'b1);
        load_text("0000\t00000 0101");
        send_text(1'b1);

        string_count = 0;
        while (board.beats_taken < BEAT_TARGET) begin
            calm = (string_count >= 40 && string_count < 70);
            if (string_count == 100) begin
                // receiver stalls while short strings keep coming
                calm = 1'b1;
                hold_cycles = 300;
                repeat (40) begin
                    compose_noise(2);
                    if ($urandom_range(0, 1)) text_q.delete();
                    send_text(1'b0);
                end
                calm = 1'b0;
                @(negedge i_clk);
                char_if.valid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end
            random_string();
            string_count++;
        end
        @(negedge i_clk);
        char_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Fed %0d character beats in %0d random strings; %0d verdicts checked.",
                 board.beats_taken, string_count, board.verdicts_seen);
        $display({"Verdicts: valid %0d, empty %0d, format %0d, zero code %0d,",
                  " region %0d, sub %0d, check %0d"},
                 board.reason_hits[RSN_VALID], board.reason_hits[RSN_EMPTY],
                 board.reason_hits[RSN_FORMAT], board.reason_hits[RSN_ZERO_CODE],
                 board.reason_hits[RSN_REGION_HI], board.reason_hits[RSN_SUB_HI],
                 board.reason_hits[RSN_CHECK]);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures", board.fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/idv_pkg.sv
sv/idv_if.sv
sv/idv_accum.sv
sv/id_number_check_digit_validator_top.sv
test/tb_id_number_check_digit_validator_top.sv
